### hdl/ihds_pkg.sv
// Package with the state codes, marker constants and result type of the header sniffer.
package ihds_pkg;

    localparam int StateW = 4;

    localparam logic [StateW-1:0] ST_SNIFF  = 4'd0;
    localparam logic [StateW-1:0] ST_PNG    = 4'd1;
    localparam logic [StateW-1:0] ST_SOI    = 4'd2;
    localparam logic [StateW-1:0] ST_FF     = 4'd3;
    localparam logic [StateW-1:0] ST_MARKER = 4'd4;
    localparam logic [StateW-1:0] ST_LENHI  = 4'd5;
    localparam logic [StateW-1:0] ST_LENLO  = 4'd6;
    localparam logic [StateW-1:0] ST_SKIP   = 4'd7;
    localparam logic [StateW-1:0] ST_SOF    = 4'd8;
    localparam logic [StateW-1:0] ST_DONE   = 4'd9;
    localparam logic [StateW-1:0] ST_FAILED = 4'd10;

    localparam logic [1:0] PH_PARSING = 2'd0;
    localparam logic [1:0] PH_DONE    = 2'd1;
    localparam logic [1:0] PH_FAILED  = 2'd2;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF15  = 8'hCF;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_JPG    = 8'hC8;
    localparam logic [7:0] MK_DAC    = 8'hCC;

    localparam logic [7:0] PNG_SIG0 = 8'h89;

    localparam int DimW = 15;
    localparam logic [31:0] DIM_MAX = 32'd32767;

    typedef struct packed {
        logic            accepted;
        logic [1:0]      phase;
        logic            dims_valid;
        logic [DimW-1:0] width;
        logic [DimW-1:0] height;
    } t_result;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4E;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0D;
            3'd5: v = 8'h0A;
            3'd6: v = 8'h1A;
            3'd7: v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'h49;
            2'd1: v = 8'h48;
            2'd2: v = 8'h44;
            2'd3: v = 8'h52;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic is_sof(input logic [7:0] m);
        return (m >= MK_SOF0) && (m <= MK_SOF15) && (m != MK_DHT) && (m != MK_JPG)
            && (m != MK_DAC);
    endfunction

    function automatic logic dim_ok(input logic [31:0] d);
        return (d != 32'd0) && (d <= DIM_MAX);
    endfunction

endpackage

### hdl/ihds_parser.sv
// Parse state registers and the per-byte update and result logic of the header sniffer.
module ihds_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output ihds_pkg::t_result o_result
);
    import ihds_pkg::*;

    logic [StateW-1:0] r_state, n_state;
    logic [4:0]        r_pos, n_pos;
    logic [31:0]       r_wacc, n_wacc;
    logic [31:0]       r_hacc, n_hacc;
    logic [7:0]        r_len_hi, n_len_hi;
    logic              r_sof_pend, n_sof_pend;
    logic [2:0]        r_held, n_held;
    logic [15:0]       r_skip, n_skip;
    logic              w_acc;
    logic [15:0]       w_len;
    logic              w_done;

    assign w_len = {r_len_hi, i_byte};

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_wacc     = r_wacc;
        n_hacc     = r_hacc;
        n_len_hi   = r_len_hi;
        n_sof_pend = r_sof_pend;
        n_held     = r_held;
        n_skip     = r_skip;
        w_acc      = 1'b0;
        unique case (r_state)
            ST_SNIFF: begin
                n_pos = 5'd1;
                if (i_byte == MK_PREFIX) begin
                    n_state = ST_SOI;
                    w_acc   = 1'b1;
                end else if (i_byte == PNG_SIG0) begin
                    n_state = ST_PNG;
                    w_acc   = 1'b1;
                end else begin
                    n_state = ST_FAILED;
                end
            end
            ST_PNG: begin
                n_pos = r_pos + 5'd1;
                w_acc = 1'b1;
                if (r_pos < 5'd8) begin
                    if (i_byte != png_sig_byte(r_pos[2:0])) begin
                        n_state = ST_FAILED;
                        n_pos   = r_pos;
                        w_acc   = 1'b0;
                    end
                end else if (r_pos >= 5'd12 && r_pos < 5'd16) begin
                    if (i_byte != ihdr_byte(r_pos[1:0])) begin
                        n_state = ST_FAILED;
                        n_pos   = r_pos;
                        w_acc   = 1'b0;
                    end
                end else if (r_pos >= 5'd16 && r_pos < 5'd20) begin
                    n_wacc = {r_wacc[23:0], i_byte};
                end else if (r_pos >= 5'd20 && r_pos < 5'd24) begin
                    n_hacc = {r_hacc[23:0], i_byte};
                    if (r_pos == 5'd23) begin
                        n_state = ST_DONE;
                        w_acc   = 1'b0;
                    end
                end
            end
            ST_SOI: begin
                if (i_byte != MK_SOI) begin
                    n_state = ST_FAILED;
                end else begin
                    n_state = ST_FF;
                    w_acc   = 1'b1;
                end
            end
            ST_FF: begin
                if (i_byte != MK_PREFIX) begin
                    n_state = ST_FAILED;
                end else begin
                    n_state = ST_MARKER;
                    w_acc   = 1'b1;
                end
            end
            ST_MARKER: begin
                w_acc = 1'b1;
                priority if (i_byte == MK_PREFIX) begin
                    n_state = ST_MARKER;
                end else if (i_byte == MK_TEM || (i_byte >= MK_RST0 && i_byte <= MK_SOI)) begin
                    n_state = ST_FF;
                end else if (i_byte == MK_EOI || i_byte == MK_SOS) begin
                    n_state = ST_FAILED;
                    w_acc   = 1'b0;
                end else begin
                    n_sof_pend = is_sof(i_byte);
                    n_state    = ST_LENHI;
                end
            end
            ST_LENHI: begin
                n_len_hi = i_byte;
                n_state  = ST_LENLO;
                w_acc    = 1'b1;
            end
            ST_LENLO: begin
                if (w_len < 16'd2 || (r_sof_pend && w_len < 16'd7)) begin
                    n_state = ST_FAILED;
                end else begin
                    w_acc = 1'b1;
                    if (r_sof_pend) begin
                        n_held  = 3'd0;
                        n_state = ST_SOF;
                    end else if (w_len == 16'd2) begin
                        n_state = ST_FF;
                    end else begin
                        n_skip  = w_len - 16'd2;
                        n_state = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                w_acc = 1'b1;
                if (r_skip <= 16'd1) begin
                    n_skip  = 16'd0;
                    n_state = ST_FF;
                end else begin
                    n_skip = r_skip - 16'd1;
                end
            end
            ST_SOF: begin
                n_held = r_held + 3'd1;
                w_acc  = 1'b1;
                unique case (r_held)
                    3'd1: n_hacc = {24'd0, i_byte};
                    3'd2: n_hacc = {r_hacc[23:0], i_byte};
                    3'd3: n_wacc = {24'd0, i_byte};
                    3'd4: begin
                        n_wacc  = {r_wacc[23:0], i_byte};
                        n_state = ST_DONE;
                        w_acc   = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign w_done = (n_state == ST_DONE);

    always_comb begin
        o_result.accepted = w_acc;
        if (w_done) begin
            o_result.phase = PH_DONE;
        end else if (n_state >= ST_FAILED) begin
            o_result.phase = PH_FAILED;
        end else begin
            o_result.phase = PH_PARSING;
        end
        o_result.dims_valid = w_done && dim_ok(n_wacc) && dim_ok(n_hacc);
        o_result.width  = o_result.dims_valid ? n_wacc[DimW-1:0] : '0;
        o_result.height = o_result.dims_valid ? n_hacc[DimW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SNIFF;
            r_pos      <= '0;
            r_wacc     <= '0;
            r_hacc     <= '0;
            r_len_hi   <= '0;
            r_sof_pend <= 1'b0;
            r_held     <= '0;
            r_skip     <= '0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_wacc     <= n_wacc;
            r_hacc     <= n_hacc;
            r_len_hi   <= n_len_hi;
            r_sof_pend <= n_sof_pend;
            r_held     <= n_held;
            r_skip     <= n_skip;
        end
    end

endmodule

### hdl/image_header_dims_sniffer_top.sv
// Top level of the header sniffer: input register, parser and result register.
//
//   Channel  Direction  Handshake             Payload
//   input    in         i_valid / o_stall     i_data_byte
//   result   out        o_valid / i_stall     o_byte_accepted, o_parse_phase, o_dims_valid,
//                                             o_image_width, o_image_height
//
// One item is taken per cycle while o_stall is low; each result passes the input register, then the result register.
// The parse state advances in the same cycle as the input register hands its byte on.
// Reset clears the parse state and both valid flags.
// A stall on the result side holds the result register and, once the input register is
// full as well, stalls the input in the same cycle.
module image_header_dims_sniffer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_byte_accepted,
    output logic [1:0]  o_parse_phase,
    output logic        o_dims_valid,
    output logic [14:0] o_image_width,
    output logic [14:0] o_image_height
);
    import ihds_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_step;

    assign w_step  = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_step;

    ihds_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_accepted = r_out.accepted;
    assign o_parse_phase   = r_out.phase;
    assign o_dims_valid    = r_out.dims_valid;
    assign o_image_width   = r_out.width;
    assign o_image_height  = r_out.height;

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_in_valid && r_in_byte == $past(i_data_byte)))
        else $error("accepted item not held in the input register");

    a_dims_need_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dims_valid) |-> (o_parse_phase == PH_DONE))
        else $error("dimensions flagged valid outside the done phase");

    a_accept_while_parsing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_accepted) |-> (o_parse_phase == PH_PARSING))
        else $error("byte accepted in a final phase");

    a_zero_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_dims_valid) |-> (o_image_width == '0 && o_image_height == '0))
        else $error("dimensions not zero while invalid");

endmodule
